FILE: sv/kdeq_pkg.sv
// ----------------------------------------------------------------------------
// kdeq_pkg
// Shared constants, register indexes and types for the key debounce event
// queue.
// ----------------------------------------------------------------------------
package kdeq_pkg;

	// event ring
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// op queue between front and back
	localparam int OPQ_DEPTH = 2;
	localparam int OPQ_PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

	// result queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam int CODE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_DOWN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_UP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_LONG    = 3'd5;

	// item commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// register reset values
	localparam logic [7:0]  FILTER_TIME_RST  = 8'd5;
	localparam logic [15:0] LONG_TIME_RST    = 16'd100;
	localparam logic [7:0]  REPEAT_SPEED_RST = 8'd0;
	localparam logic [7:0]  CODE_DOWN_RST    = 8'd1;
	localparam logic [7:0]  CODE_UP_RST      = 8'd2;
	localparam logic [7:0]  CODE_LONG_RST    = 8'd3;
	localparam logic [8:0]  FILTER_COUNT_RST = 9'(FILTER_TIME_RST / 2);

	typedef logic [PTR_W-1:0] ptr_t;

	// one classified item, as handed from front to back
	typedef struct packed {
		logic              is_pop;
		logic              hit;      // pop finds a queued code
		ptr_t              rd_addr;
		logic [1:0]        wr_cnt;   // ring writes, 0..2
		ptr_t              wr_addr0;
		ptr_t              wr_addr1;
		logic [CODE_W-1:0] code0;
		logic [CODE_W-1:0] code1;
		logic              held;
	} op_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              held;
	} res_t;

	typedef struct packed {
		logic [OUTQ_CNT_W-1:0] out_cnt;
		logic                  valid_s2;
	} bk_status_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

FILE: sv/kdeq_front.sv
// ----------------------------------------------------------------------------
// kdeq_front
// Configuration registers, debounce / long press / repeat tracking and ring
// pointer bookkeeping. Turns each accepted item into one op for the back end.
// ----------------------------------------------------------------------------
module kdeq_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kdeq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdeq_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             accept,
	input  logic                             cmd,
	input  logic                             key_pressed,
	output kdeq_pkg::op_t                    op
);
	import kdeq_pkg::*;

	logic [7:0]  filter_time_q, repeat_speed_q;
	logic [15:0] long_time_q;
	logic [7:0]  code_down_q, code_up_q, code_long_q;

	logic [8:0]  fc_q, fc_n;
	logic        held_q, held_n;
	logic [15:0] lc_q, lc_n;
	logic [7:0]  rc_q, rc_n;
	ptr_t        rp_q, rp_n, wp_q, wp_n;

	logic [8:0]  ft9, ft2, rc_inc;
	logic [15:0] lc_inc;
	logic        push_down, push_2nd, hit;
	logic [7:0]  code_2nd;

	always_comb begin
		ft9    = {1'b0, filter_time_q};
		ft2    = {filter_time_q, 1'b0};
		rc_inc = {1'b0, rc_q} + 9'd1;
		lc_inc = lc_q + 16'd1;

		fc_n      = fc_q;
		held_n    = held_q;
		lc_n      = lc_q;
		rc_n      = rc_q;
		rp_n      = rp_q;
		push_down = 1'b0;
		push_2nd  = 1'b0;
		code_2nd  = code_down_q;
		hit       = 1'b0;

		if (cmd == CMD_POP) begin
			hit = (rp_q != wp_q);
			if (hit)
				rp_n = next_ptr(rp_q);
		end else if (key_pressed) begin
			if (fc_q < ft9) begin
				fc_n = ft9;
			end else if (fc_q < ft2) begin
				fc_n = fc_q + 9'd1;
			end else begin
				// stable pressed
				if (!held_q) begin
					held_n    = 1'b1;
					push_down = (code_down_q != '0);
				end
				if (long_time_q != '0) begin
					if (lc_q < long_time_q) begin
						lc_n = lc_inc;
						if (lc_inc == long_time_q && code_long_q != '0) begin
							push_2nd = 1'b1;
							code_2nd = code_long_q;
						end
					end else if (repeat_speed_q != '0) begin
						// repeat code goes out even when it is zero
						if (rc_inc >= {1'b0, repeat_speed_q}) begin
							rc_n     = '0;
							push_2nd = 1'b1;
							code_2nd = code_down_q;
						end else begin
							rc_n = rc_inc[7:0];
						end
					end
				end
			end
		end else begin
			if (fc_q > ft9) begin
				fc_n = ft9;
			end else if (fc_q != '0) begin
				fc_n = fc_q - 9'd1;
			end else if (held_q) begin
				held_n    = 1'b0;
				push_down = 1'b0;
				push_2nd  = (code_up_q != '0);
				code_2nd  = code_up_q;
			end
			lc_n = '0;
			rc_n = '0;
		end

		op          = '0;
		op.is_pop   = (cmd == CMD_POP);
		op.hit      = hit;
		op.rd_addr  = rp_q;
		op.wr_addr0 = wp_q;
		op.wr_addr1 = next_ptr(wp_q);
		op.held     = held_n;
		wp_n        = wp_q;
		if (push_down && push_2nd) begin
			op.wr_cnt = 2'd2;
			op.code0  = code_down_q;
			op.code1  = code_2nd;
			wp_n      = next_ptr(next_ptr(wp_q));
		end else if (push_down) begin
			op.wr_cnt = 2'd1;
			op.code0  = code_down_q;
			wp_n      = next_ptr(wp_q);
		end else if (push_2nd) begin
			op.wr_cnt = 2'd1;
			op.code0  = code_2nd;
			wp_n      = next_ptr(wp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_time_q  <= FILTER_TIME_RST;
			long_time_q    <= LONG_TIME_RST;
			repeat_speed_q <= REPEAT_SPEED_RST;
			code_down_q    <= CODE_DOWN_RST;
			code_up_q      <= CODE_UP_RST;
			code_long_q    <= CODE_LONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_TIME:  filter_time_q  <= cfg_data[7:0];
				REG_LONG_TIME:    long_time_q    <= cfg_data[15:0];
				REG_REPEAT_SPEED: repeat_speed_q <= cfg_data[7:0];
				REG_CODE_DOWN:    code_down_q    <= cfg_data[7:0];
				REG_CODE_UP:      code_up_q      <= cfg_data[7:0];
				REG_CODE_LONG:    code_long_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= FILTER_COUNT_RST;
			held_q <= 1'b0;
			lc_q   <= '0;
			rc_q   <= '0;
			rp_q   <= '0;
			wp_q   <= '0;
		end else if (accept) begin
			fc_q   <= fc_n;
			held_q <= held_n;
			lc_q   <= lc_n;
			rc_q   <= rc_n;
			rp_q   <= rp_n;
			wp_q   <= wp_n;
		end
	end

endmodule

FILE: sv/kdeq_opq.sv
// ----------------------------------------------------------------------------
// kdeq_opq
// Short queue of classified ops between the front and back ends.
// ----------------------------------------------------------------------------
module kdeq_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  kdeq_pkg::op_t wr_data,
	output logic          full,
	output logic          valid,
	input  logic          rd_en,
	output kdeq_pkg::op_t rd_data
);
	import kdeq_pkg::*;

	op_t                  slot_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = slot_q[rd_ptr_q];

	function automatic logic [OPQ_PTR_W-1:0] bump(input logic [OPQ_PTR_W-1:0] p);
		return (p == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : OPQ_PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= bump(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= bump(rd_ptr_q);
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/kdeq_back.sv
// ----------------------------------------------------------------------------
// kdeq_back
// Event ring memory and result queue. Carries out the ring writes and reads
// of each op in order and queues one result per op.
// ----------------------------------------------------------------------------
module kdeq_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	input  kdeq_pkg::op_t        op,
	output logic                 op_rd,
	input  logic                 pop,
	output logic                 empty,
	output kdeq_pkg::res_t       res,
	output kdeq_pkg::bk_status_t status
);
	import kdeq_pkg::*;

	logic [CODE_W-1:0] ring [QUEUE_DEPTH];

	logic                  phase_q;
	logic                  split, first_wr, fin, credit;
	logic                  mem_we, mem_re;
	ptr_t                  mem_wa;
	logic [CODE_W-1:0]     mem_wd;
	logic [OUTQ_CNT_W:0]   used;

	logic                  valid_s2, hit_s2, held_s2;
	logic [CODE_W-1:0]     rdata_s2;

	res_t                  outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] owr_q, ord_q;
	logic [OUTQ_CNT_W-1:0] ocnt_q;
	logic                  out_pop;
	res_t                  out_wd;

	// conservative: a result in flight always has a free slot
	assign used   = {1'b0, ocnt_q} + {{OUTQ_CNT_W{1'b0}}, valid_s2};
	assign credit = (used < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

	// an item with two ring writes does the first one alone, before it finishes
	assign split    = (op.wr_cnt == 2'd2) && !phase_q;
	assign first_wr = op_valid && split;
	assign fin      = op_valid && !split && credit;
	assign op_rd    = fin;

	assign mem_we = first_wr || (fin && op.wr_cnt != 2'd0);
	assign mem_wa = phase_q ? op.wr_addr1 : op.wr_addr0;
	assign mem_wd = phase_q ? op.code1 : op.code0;
	assign mem_re = fin && op.is_pop && op.hit;

	always_ff @(posedge clk) begin
		if (mem_we)
			ring[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_s2 <= ring[op.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			hit_s2  <= op.is_pop && op.hit;
			held_s2 <= op.held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (first_wr)
				phase_q <= 1'b1;
			else if (fin)
				phase_q <= 1'b0;
			valid_s2 <= fin;
		end
	end

	// result queue
	assign out_wd.code = hit_s2 ? rdata_s2 : '0;
	assign out_wd.held = held_s2;
	assign empty       = (ocnt_q == '0);
	assign out_pop     = pop && !empty;
	assign res         = outq_q[ord_q];

	function automatic logic [OUTQ_PTR_W-1:0] bump(input logic [OUTQ_PTR_W-1:0] p);
		return (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : OUTQ_PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (valid_s2)
			outq_q[owr_q] <= out_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s2)
				owr_q <= bump(owr_q);
			if (out_pop)
				ord_q <= bump(ord_q);
			case ({valid_s2, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign status.out_cnt  = ocnt_q;
	assign status.valid_s2 = valid_s2;

endmodule

FILE: sv/key_debounce_event_queue.sv
// ----------------------------------------------------------------------------
// key_debounce_event_queue
// Key debounce with long press and auto repeat, feeding a ring of event codes.
// ----------------------------------------------------------------------------
// Each item is a tick (cmd 0, one raw key sample) or a pop (cmd 1) and yields
// exactly one result: the popped code (0 on a tick or from an empty ring) and
// the debounced key state after the item. Items are taken one per cycle unless
// full is high; the front end updates all debounce counters and ring pointers
// in the cycle of acceptance. The back end has a single write port on the
// event ring, so the rare tick that queues two codes at once (press and long
// code together) needs two writes, which can back up the op queue and hold off
// the input. A result passes through the op queue, the ring read register and
// the result queue to the output. The ring overwrites without a full check:
// after sixteen unread codes it reads empty. Configure only while idle.
// ----------------------------------------------------------------------------
module key_debounce_event_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kdeq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdeq_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic                           cmd,
	input  logic                           key_pressed,
	output logic                           empty,
	input  logic                           pop,
	output logic [kdeq_pkg::CODE_W-1:0]    event_code,
	output logic                           debounced_state
);
	import kdeq_pkg::*;

	logic       accept;
	op_t        op_in, op_out;
	logic       opq_full, opq_valid, opq_rd;
	res_t       res;
	bk_status_t bk_status;

	assign accept = push && !opq_full;
	assign full   = opq_full;

	kdeq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.cmd         (cmd),
		.key_pressed (key_pressed),
		.op          (op_in)
	);

	kdeq_opq u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (op_in),
		.full    (opq_full),
		.valid   (opq_valid),
		.rd_en   (opq_rd),
		.rd_data (op_out)
	);

	kdeq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (opq_valid),
		.op       (op_out),
		.op_rd    (opq_rd),
		.pop      (pop),
		.empty    (empty),
		.res      (res),
		.status   (bk_status)
	);

	assign event_code      = res.code;
	assign debounced_state = res.held;

`ifndef SYNTH
	// result queue never overruns
	a_outq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.out_cnt <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overrun");

	// a full result queue blocks new results in flight
	a_outq_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.out_cnt == OUTQ_CNT_W'(OUTQ_DEPTH)) |-> !bk_status.valid_s2)
		else $error("result written into full queue");

	// an accepted item is waiting in the op queue on the next cycle
	a_op_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> opq_valid)
		else $error("accepted item lost before back end");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the key debounce event queue.
// ----------------------------------------------------------------------------
// Sends ticks and pops through the input handshake. A local mirror of the
// debounce counters and the event ring predicts each result, and the results
// are checked in order as they are popped. Both sides stall at random. One
// phase holds the result side off so long that the input backs up. Settings are
// changed only while the block is idle, and they include the extremes.
// ----------------------------------------------------------------------------
module tb;
	import kdeq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 8;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_DAT_W-1:0] cfg_data    = '0;
	logic                 push        = 1'b0;
	logic                 full;
	logic                 cmd         = CMD_TICK;
	logic                 key_pressed = 1'b0;
	logic                 empty;
	logic                 pop         = 1'b0;
	logic [CODE_W-1:0]    event_code;
	logic                 debounced_state;

	// mirror of the block's registers and state
	int unsigned filter_time_q  = FILTER_TIME_RST;
	int unsigned long_time_q    = LONG_TIME_RST;
	int unsigned repeat_speed_q = REPEAT_SPEED_RST;
	int unsigned code_down_q    = CODE_DOWN_RST;
	int unsigned code_up_q      = CODE_UP_RST;
	int unsigned code_long_q    = CODE_LONG_RST;
	int unsigned filter_cnt     = FILTER_COUNT_RST;
	int unsigned long_cnt       = 0;
	int unsigned repeat_cnt     = 0;
	logic        held_q         = 1'b0;
	logic [CODE_W-1:0] code_ring [QUEUE_DEPTH];
	ptr_t        rd_ptr         = '0;
	ptr_t        wr_ptr         = '0;

	res_t pending_events [$];
	int   errors       = 0;
	int   items_sent   = 0;
	int   stall_cycles = 0;
	bit   tx_idle      = 1'b1;
	bit   rx_idle      = 1'b1;
	bit   rx_hold_req  = 1'b0;

	key_debounce_event_queue DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.cmd             (cmd),
		.key_pressed     (key_pressed),
		.empty           (empty),
		.pop             (pop),
		.event_code      (event_code),
		.debounced_state (debounced_state)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic ptr_t ring_advance(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// no full check: the oldest unread codes get overwritten
	function automatic void ring_put(input int unsigned code);
		code_ring[wr_ptr] = CODE_W'(code);
		wr_ptr = ring_advance(wr_ptr);
	endfunction

	function automatic res_t debounce_step(input logic op, input logic level);
		res_t r;
		r.code = '0;
		if (op == CMD_POP) begin
			if (rd_ptr != wr_ptr) begin
				r.code = code_ring[rd_ptr];
				rd_ptr = ring_advance(rd_ptr);
			end
		end else if (level) begin
			if (filter_cnt < filter_time_q) begin
				filter_cnt = filter_time_q;
			end else if (filter_cnt < 2 * filter_time_q) begin
				filter_cnt++;
			end else begin
				if (!held_q) begin
					held_q = 1'b1;
					if (code_down_q != 0)
						ring_put(code_down_q);
				end
				if (long_time_q != 0) begin
					if (long_cnt < long_time_q) begin
						long_cnt++;
						if (long_cnt == long_time_q && code_long_q != 0)
							ring_put(code_long_q);
					end else if (repeat_speed_q != 0) begin
						repeat_cnt++;
						if (repeat_cnt >= repeat_speed_q) begin
							repeat_cnt = 0;
							// repeats are queued even with a zero press code
							ring_put(code_down_q);
						end
						repeat_cnt &= 8'hFF;
					end
				end
			end
		end else begin
			if (filter_cnt > filter_time_q) begin
				filter_cnt = filter_time_q;
			end else if (filter_cnt != 0) begin
				filter_cnt--;
			end else if (held_q) begin
				held_q = 1'b0;
				if (code_up_q != 0)
					ring_put(code_up_q);
			end
			long_cnt   = 0;
			repeat_cnt = 0;
		end
		r.held = held_q;
		return r;
	endfunction

	task automatic send_item(input logic op, input logic level);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		cmd         <= op;
		key_pressed <= level;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_events.push_back(debounce_step(op, level));
		items_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DAT_W'(value);
		@(posedge clk);
		case (idx)
			REG_FILTER_TIME:  filter_time_q  = value & 8'hFF;
			REG_LONG_TIME:    long_time_q    = value & 16'hFFFF;
			REG_REPEAT_SPEED: repeat_speed_q = value & 8'hFF;
			REG_CODE_DOWN:    code_down_q    = value & 8'hFF;
			REG_CODE_UP:      code_up_q      = value & 8'hFF;
			REG_CODE_LONG:    code_long_q    = value & 8'hFF;
			default: ;
		endcase
	endtask

	task automatic load_config(input int unsigned ft, input int unsigned lt,
			input int unsigned rs, input int unsigned cd, input int unsigned cu,
			input int unsigned cl);
		wait_idle();
		write_reg(REG_FILTER_TIME, ft);
		write_reg(REG_LONG_TIME, lt);
		write_reg(REG_REPEAT_SPEED, rs);
		write_reg(REG_CODE_DOWN, cd);
		write_reg(REG_CODE_UP, cu);
		write_reg(REG_CODE_LONG, cl);
		cfg_we <= 1'b0;
	endtask

	// a run of ticks at one key level, with optional bounce and pops mixed in
	task automatic drive_key(input logic level, input int ticks, input int noise_pct,
			input int pop_pct);
		repeat (ticks) begin
			if ($urandom_range(0, 99) < pop_pct)
				send_item(CMD_POP, 1'($urandom_range(0, 1)));
			else
				send_item(CMD_TICK, ($urandom_range(0, 99) < noise_pct) ? ~level : level);
		end
	endtask

	task automatic test_reset_defaults();
		send_item(CMD_POP, 1'b1);
		repeat (7) send_item(CMD_TICK, 1'b1);
		send_item(CMD_POP, 1'b0);
		send_item(CMD_POP, 1'b1);
	endtask

	// zero filter, long press on the first held tick, repeat with a zero code
	task automatic test_zero_codes();
		load_config(0, 1, 1, 0, 255, 255);
		repeat (2) send_item(CMD_TICK, 1'b0);
		repeat (2) send_item(CMD_TICK, 1'b1);
		repeat (4) send_item(CMD_POP, 1'b1);
	endtask

	// press and long code on one tick, then enough repeats that the ring wraps
	task automatic test_ring_wrap();
		load_config(0, 1, 1, 255, 0, 7);
		repeat (2) send_item(CMD_TICK, 1'b0);
		repeat (15) send_item(CMD_TICK, 1'b1);
		repeat (2) send_item(CMD_POP, 1'b0);
		repeat (3) send_item(CMD_TICK, 1'b1);
		repeat (4) send_item(CMD_POP, 1'b0);
	endtask

	task automatic test_backpressure();
		load_config(0, 3, 2, 8'h5A, 8'hA5, 8'h3C);
		tx_idle     = 1'b0;
		rx_hold_req = 1'b1;
		drive_key(1'b1, 30, 0, 30);
		drive_key(1'b0, 10, 0, 30);
		tx_idle = 1'b1;
		// sender waits for every result before going on
		wait_idle();
		drive_key(1'b0, 6, 0, 60);
	endtask

	task automatic test_extreme_settings();
		load_config(255, 65535, 255, 255, 255, 255);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		drive_key(1'b1, 280, 0, 5);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		load_config(0, 0, 0, 0, 0, 0);
		drive_key(1'b0, 6, 0, 20);
		drive_key(1'b1, 6, 0, 20);
		drive_key(1'b0, 6, 0, 20);
	endtask

	task automatic test_random_phases();
		int   start;
		logic level;
		repeat (7) begin
			load_config($urandom_range(0, 4), $urandom_range(0, 12), $urandom_range(0, 4),
				($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255),
				($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255),
				($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			start   = items_sent;
			level   = 1'b1;
			while (items_sent - start < 80) begin
				drive_key(level, $urandom_range(1, 20),
					($urandom_range(0, 4) == 0) ? 40 : 0, 30);
				level = ~level;
			end
		end
	endtask

	// result side: random pop gaps, plus one long hold on request
	initial begin : result_sink
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 7) : 0;
				repeat (wait_cycles) begin
					pop <= 1'b0;
					@(posedge clk);
				end
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result: event_code %0d, debounced_state %0b",
					event_code, debounced_state);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want.code) begin
					$error("event_code: expected %0d, actual %0d", want.code, event_code);
					errors++;
				end
				if (debounced_state !== want.held) begin
					$error("debounced_state: expected %0b, actual %0b",
						want.held, debounced_state);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("key_debounce_event_queue test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_codes();
		test_ring_wrap();
		test_backpressure();
		test_extreme_settings();
		test_random_phases();
		wait_idle();
		if (errors == 0)
			$display("key_debounce_event_queue test passed");
		else
			$display("key_debounce_event_queue test failed");
		$finish;
	end

endmodule
